@@ rtl/lppd_pkg.sv @@
// ----------------------------------------------------------------------------
// lppd_pkg
// Shared types and constants of the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lppd_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LEN     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKET_LEN = 4'd1;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [3:0]  HEADER_LEN_RESET = 4'd5;
  localparam logic [15:0] MAX_LEN_RESET    = 16'd4096;

  // Usable header length range
  localparam logic [3:0] HDR_MIN = 4'd4;
  localparam logic [3:0] HDR_MAX = 4'd8;

  // Header byte positions
  localparam logic [3:0] HB_LEN_LO = 4'd0;
  localparam logic [3:0] HB_LEN_HI = 4'd1;
  localparam logic [3:0] HB_ID_LO  = 4'd2;
  localparam logic [3:0] HB_ID_HI  = 4'd3;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_OVERSIZE = 2'd2;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] length;
    logic [7:0]  data;
    logic [15:0] offset;
    logic        has_payload;
    logic        first;
    logic        last;
    logic [1:0]  status;
  } lppd_cmd_t;

  typedef struct packed {
    logic      push;
    lppd_cmd_t cmd;
  } lppd_qwr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lppd_qstat_t;

endpackage

@@ rtl/lppd_if.sv @@
// ----------------------------------------------------------------------------
// lppd_if
// Channel interfaces: input bytes, results and configuration writes.
// ----------------------------------------------------------------------------
interface lppd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       flush;

  modport source (output valid, output rx_byte, output flush, input ready);
  modport sink   (input valid, input rx_byte, input flush, output ready);
endinterface

interface lppd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] packet_id;
  logic [15:0] packet_length;
  logic [7:0]  data_byte;
  logic [15:0] payload_offset;
  logic        has_payload;
  logic        first_of_packet;
  logic        last_of_packet;
  logic [1:0]  status;

  modport source (output valid, output packet_id, output packet_length, output data_byte,
                  output payload_offset, output has_payload, output first_of_packet,
                  output last_of_packet, output status, input ready);
  modport sink   (input valid, input packet_id, input packet_length, input data_byte,
                  input payload_offset, input has_payload, input first_of_packet,
                  input last_of_packet, input status, output ready);
endinterface

interface lppd_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/lppd_front.sv @@
// ----------------------------------------------------------------------------
// lppd_front
// Header parser: takes bytes, tracks packet state, queues result commands.
// ----------------------------------------------------------------------------
module lppd_front #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  lppd_in_if.sink             in_if,
  lppd_cfg_if.sink            cfg_if,
  input  lppd_pkg::lppd_qstat_t qstat,
  output lppd_pkg::lppd_qwr_t   qwr
);
  import lppd_pkg::*;

  localparam int LW = LENGTH_BITS;

  logic [3:0]    hdr_len_r;
  logic [15:0]   max_len_r;
  logic [3:0]    hc_r,   hc_nxt;
  logic [LW-1:0] len_r,  len_nxt;
  logic [15:0]   id_r,   id_nxt;
  logic [LW-1:0] pc_r,   pc_nxt;
  logic [LW-1:0] size_r, size_nxt;
  logic          pay_r,  pay_nxt;
  logic          drop_r, drop_nxt;

  logic [3:0]    hlen;
  logic [3:0]    hc_inc;
  logic          take;
  logic [LW-1:0] len_new;
  logic [15:0]   id_new;
  logic [LW-1:0] size_calc;
  logic          is_short;
  logic          is_over;
  logic [LW:0]   pc_inc;
  logic          pay_last;

  assign take         = in_if.valid && in_if.ready;
  assign in_if.ready  = !qstat.full;
  assign cfg_if.ready = 1'b1;

  always_comb begin
    if (hdr_len_r < HDR_MIN) begin
      hlen = HDR_MIN;
    end else if (hdr_len_r > HDR_MAX) begin
      hlen = HDR_MAX;
    end else begin
      hlen = hdr_len_r;
    end
  end

  always_comb begin
    len_new = len_r;
    id_new  = id_r;
    case (hc_r)
      HB_LEN_LO: begin
        len_new = LW'(32'(in_if.rx_byte));
        id_new  = 16'd0;
      end
      HB_LEN_HI: len_new = LW'(32'(len_r) | (32'(in_if.rx_byte) << 8));
      HB_ID_LO:  id_new  = {8'd0, in_if.rx_byte};
      HB_ID_HI:  id_new  = id_r | {in_if.rx_byte, 8'd0};
      default:   ;
    endcase
  end

  assign hc_inc    = hc_r + 4'd1;
  assign size_calc = len_new - LW'(hlen);
  assign is_short  = 32'(len_new) < 32'(hlen);
  assign is_over   = 32'(len_new) > 32'(max_len_r);
  assign pc_inc    = {1'b0, pc_r} + {{LW{1'b0}}, 1'b1};
  assign pay_last  = pc_inc >= {1'b0, size_r};

  always_comb begin
    hc_nxt   = hc_r;
    len_nxt  = len_r;
    id_nxt   = id_r;
    pc_nxt   = pc_r;
    size_nxt = size_r;
    pay_nxt  = pay_r;
    drop_nxt = drop_r;

    qwr.push            = 1'b0;
    qwr.cmd.id          = id_new;
    qwr.cmd.length      = 16'(32'(len_new));
    qwr.cmd.data        = in_if.rx_byte;
    qwr.cmd.offset      = 16'(32'(pc_r));
    qwr.cmd.has_payload = 1'b0;
    qwr.cmd.first       = pc_r == '0;
    qwr.cmd.last        = pay_last;
    qwr.cmd.status      = ST_OK;

    if (take) begin
      if (in_if.flush) begin
        // drop the partial packet
        hc_nxt   = '0;
        len_nxt  = '0;
        id_nxt   = '0;
        pc_nxt   = '0;
        size_nxt = '0;
        pay_nxt  = 1'b0;
        drop_nxt = 1'b0;
      end else if (!pay_r) begin
        len_nxt = len_new;
        id_nxt  = id_new;
        if (hc_inc < hlen) begin
          hc_nxt = hc_inc;
        end else begin
          hc_nxt = '0;
          pc_nxt = '0;
          if (is_short) begin
            qwr.push       = 1'b1;
            qwr.cmd.status = ST_SHORT;
            size_nxt       = '0;
          end else if (is_over) begin
            qwr.push       = 1'b1;
            qwr.cmd.status = ST_OVERSIZE;
            size_nxt       = size_calc;
            pay_nxt        = size_calc != '0;
            drop_nxt       = size_calc != '0;
          end else if (size_calc == '0) begin
            qwr.push = 1'b1;
            size_nxt = '0;
          end else begin
            size_nxt = size_calc;
            pay_nxt  = 1'b1;
            drop_nxt = 1'b0;
          end
        end
      end else begin
        // payload byte: pass through unless skipping an oversize packet
        qwr.cmd.id          = id_r;
        qwr.cmd.length      = 16'(32'(len_r));
        qwr.cmd.has_payload = 1'b1;
        qwr.push            = !drop_r;
        if (pay_last) begin
          pc_nxt   = '0;
          size_nxt = '0;
          pay_nxt  = 1'b0;
          drop_nxt = 1'b0;
        end else begin
          pc_nxt = pc_inc[LW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_len_r <= HEADER_LEN_RESET;
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        CFG_HEADER_LEN:     hdr_len_r <= cfg_if.data[3:0];
        CFG_MAX_PACKET_LEN: max_len_r <= cfg_if.data[15:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r   <= '0;
      len_r  <= '0;
      id_r   <= '0;
      pc_r   <= '0;
      size_r <= '0;
      pay_r  <= 1'b0;
      drop_r <= 1'b0;
    end else begin
      hc_r   <= hc_nxt;
      len_r  <= len_nxt;
      id_r   <= id_nxt;
      pc_r   <= pc_nxt;
      size_r <= size_nxt;
      pay_r  <= pay_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

@@ rtl/lppd_queue.sv @@
// ----------------------------------------------------------------------------
// lppd_queue
// Short FIFO of result commands between the parser and the output stage.
// ----------------------------------------------------------------------------
module lppd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lppd_pkg::lppd_qwr_t   qwr,
  input  logic                  pop,
  output lppd_pkg::lppd_qstat_t qstat,
  output lppd_pkg::lppd_cmd_t   rd_cmd
);
  import lppd_pkg::*;

  lppd_cmd_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r,  count_nxt;

  assign qstat.full  = count_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign qstat.empty = count_r == '0;
  assign rd_cmd      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(qwr.push);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    count_nxt  = count_r + (QPTR_W+1)'(qwr.push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (qwr.push) begin
      slot_r[wr_ptr_r] <= qwr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/lppd_back.sv @@
// ----------------------------------------------------------------------------
// lppd_back
// Output stage: pops commands, formats result fields, holds them on stall.
// ----------------------------------------------------------------------------
module lppd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lppd_pkg::lppd_qstat_t qstat,
  input  lppd_pkg::lppd_cmd_t   rd_cmd,
  output logic                  pop,
  lppd_out_if.source            out_if
);
  import lppd_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  lppd_cmd_t out_cmd_r,   out_cmd_nxt;

  assign pop = !qstat.empty && (!out_valid_r || out_if.ready);

  always_comb begin
    out_cmd_nxt   = out_cmd_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    if (pop) begin
      out_valid_nxt = 1'b1;
      out_cmd_nxt   = rd_cmd;
      // header-only result: blank payload fields, mark as whole packet
      if (!rd_cmd.has_payload) begin
        out_cmd_nxt.data   = 8'd0;
        out_cmd_nxt.offset = 16'd0;
        out_cmd_nxt.first  = 1'b1;
        out_cmd_nxt.last   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_cmd_r <= out_cmd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.packet_id       = out_cmd_r.id;
  assign out_if.packet_length   = out_cmd_r.length;
  assign out_if.data_byte       = out_cmd_r.data;
  assign out_if.payload_offset  = out_cmd_r.offset;
  assign out_if.has_payload     = out_cmd_r.has_payload;
  assign out_if.first_of_packet = out_cmd_r.first;
  assign out_if.last_of_packet  = out_cmd_r.last;
  assign out_if.status          = out_cmd_r.status;

endmodule

@@ rtl/length_prefixed_packet_deframer.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer
// Cuts a received byte stream into length-prefixed packets, tagging each
// payload byte with id, length, offset, first/last flags and status.
//
// Usage:
//   in_if  : one stream byte per transaction, or a flush (byte ignored)
//            that drops any partial packet and produces nothing.
//   out_if : one result per payload byte; one header-only result for empty,
//            short (status 1) or oversize (status 2) packets. Oversize
//            payload is skipped silently.
//   cfg_if : index 0 header_len (clamped to 4..8), index 1 max_packet_len.
//            Always ready; write only while the block is idle.
// Timing: one byte per cycle while the command queue is not full. A result is
//   queued at the edge that takes its byte and reaches out_if through the
//   output register. The header/payload counter and compare set the rate.
// Stall: a 4-deep command queue and the output register absorb receiver
//   stalls; in_if.ready drops only when the queue is full.
// Reset: synchronous, active low; registers return to header_len 5 and
//   max_packet_len 4096, the parser waits for a header, queue empties.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  lppd_in_if.sink     in_if,
  lppd_out_if.source  out_if,
  lppd_cfg_if.sink    cfg_if
);
  import lppd_pkg::*;

  lppd_qwr_t   qwr;
  lppd_qstat_t qstat;
  lppd_cmd_t   rd_cmd;
  logic        pop;

  // front: parse headers, count payload, queue result commands
  lppd_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .cfg_if (cfg_if),
    .qstat  (qstat),
    .qwr    (qwr)
  );

  // queue: decouple parser from receiver back-pressure
  lppd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .qwr    (qwr),
    .pop    (pop),
    .qstat  (qstat),
    .rd_cmd (rd_cmd)
  );

  // back: format and hold results for the receiver
  lppd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .qstat  (qstat),
    .rd_cmd (rd_cmd),
    .pop    (pop),
    .out_if (out_if)
  );

endmodule

@@ verif/length_prefixed_packet_deframer_tb.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_tb
// Self-checking bench for the packet deframer. Feeds byte streams built from
// well-formed, short, oversize and truncated packets plus raw noise, predicts
// every result with a cycle-free model of the parser, and checks each result
// in order. Idles both sides in random bursts and steps the configuration
// through its extremes between traffic phases.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer_tb;
  import lppd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
  localparam int unsigned PIPE_SETTLE    = 6;     // parser edge + queue + output register
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 4'hF;  // index with no register behind it

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       flush;
  } stream_item_t;

  logic clk;
  logic rst_n;

  lppd_in_if  in_ch ();
  lppd_out_if out_ch ();
  lppd_cfg_if cfg_ch ();

  length_prefixed_packet_deframer #(.LENGTH_BITS(16)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Stream bytes waiting for the driver, and packet results waiting for the DUT
  stream_item_t rx_stream_q[$];
  lppd_cmd_t    due_results[$];
  int unsigned  queued_items;

  // Mirror of the parser: configuration and per-packet state
  logic [3:0]  m_hdr_len = HEADER_LEN_RESET;
  logic [15:0] m_max     = MAX_LEN_RESET;
  logic [3:0]  m_hdr_cnt = '0;
  logic [15:0] m_len     = '0;
  logic [15:0] m_id      = '0;
  logic [15:0] m_pay_cnt = '0;
  logic [15:0] m_size    = '0;
  logic        m_in_pay  = 1'b0;
  logic        m_dropping = 1'b0;

  // Handshake bookkeeping shared between the posedge monitor and negedge drivers
  logic        in_taken, cfg_taken, out_taken;
  int unsigned quiet_cycles;
  int unsigned mismatches;

  // Idle shaping
  int unsigned  in_gap_pct, out_stall_pct;
  int unsigned  in_gap_left, out_stall_left;
  stream_item_t drive_item;
  logic         drive_valid;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Parser mirror
  // --------------------------------------------------------------------------

  // Header length as the parser uses it: clamp into 4..8.
  function automatic logic [3:0] eff_hdr_len();
    if (m_hdr_len < HDR_MIN) return HDR_MIN;
    if (m_hdr_len > HDR_MAX) return HDR_MAX;
    return m_hdr_len;
  endfunction

  function automatic void restart_header();
    m_hdr_cnt  = '0;
    m_pay_cnt  = '0;
    m_size     = '0;
    m_in_pay   = 1'b0;
    m_dropping = 1'b0;
  endfunction

  function automatic void add_result(logic [7:0] data, logic [15:0] offset, logic has,
                                     logic first_f, logic last_f, logic [1:0] st);
    lppd_cmd_t r;
    r.id          = m_id;
    r.length      = m_len;
    r.data        = has ? data : 8'h00;
    r.offset      = has ? offset : 16'h0000;
    r.has_payload = has;
    r.first       = first_f;
    r.last        = last_f;
    r.status      = st;
    due_results.push_back(r);
  endfunction

  // Advance the mirror by one accepted stream transaction.
  function automatic void deframe_byte(logic [7:0] b, logic flush);
    logic [3:0]  hl;
    logic [16:0] nxt;
    logic        fin;
    hl = eff_hdr_len();
    if (flush) begin
      m_len = '0;
      m_id  = '0;
      restart_header();
    end else if (!m_in_pay) begin
      case (m_hdr_cnt)
        HB_LEN_LO: begin
          m_len = {8'h00, b};
          m_id  = '0;
        end
        HB_LEN_HI: m_len[15:8] = b;
        HB_ID_LO:  m_id = {8'h00, b};
        HB_ID_HI:  m_id[15:8] = b;
        default: ;
      endcase
      m_hdr_cnt = m_hdr_cnt + 4'd1;
      if (m_hdr_cnt >= hl) begin
        m_hdr_cnt = '0;
        if (m_len < {12'h000, hl}) begin
          // short length wins over the oversize test
          add_result(8'h00, 16'h0000, 1'b0, 1'b1, 1'b1, ST_SHORT);
          restart_header();
        end else begin
          m_size    = m_len - {12'h000, hl};
          m_pay_cnt = '0;
          if (m_len > m_max) begin
            add_result(8'h00, 16'h0000, 1'b0, 1'b1, 1'b1, ST_OVERSIZE);
            if (m_size != 0) begin
              m_in_pay   = 1'b1;
              m_dropping = 1'b1;
            end else begin
              restart_header();
            end
          end else if (m_size == 0) begin
            add_result(8'h00, 16'h0000, 1'b0, 1'b1, 1'b1, ST_OK);
            restart_header();
          end else begin
            m_in_pay   = 1'b1;
            m_dropping = 1'b0;
          end
        end
      end
    end else begin
      nxt = {1'b0, m_pay_cnt} + 17'd1;
      fin = (nxt >= {1'b0, m_size});
      if (!m_dropping)
        add_result(b, m_pay_cnt, 1'b1, m_pay_cnt == 0, fin, ST_OK);
      if (fin)
        restart_header();
      else
        m_pay_cnt = nxt[15:0];
    end
  endfunction

  // --------------------------------------------------------------------------
  // Error reporting
  // --------------------------------------------------------------------------

  function automatic string fmt_result(lppd_cmd_t r);
    return $sformatf("id=%h len=%h data=%h off=%h pay=%b first=%b last=%b st=%0d",
                     r.id, r.length, r.data, r.offset, r.has_payload, r.first, r.last,
                     r.status);
  endfunction

  // Print only the first ten; count the rest.
  function automatic void flag_error(string msg);
    if (mismatches < 10)
      $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: sample every channel at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    lppd_cmd_t seen;
    lppd_cmd_t want;
    if (!rst_n) begin
      in_taken     = 1'b0;
      cfg_taken    = 1'b0;
      out_taken    = 1'b0;
      quiet_cycles = 0;
    end else begin
      in_taken  = in_ch.valid && in_ch.ready;
      cfg_taken = cfg_ch.valid && cfg_ch.ready;
      out_taken = out_ch.valid && out_ch.ready;

      // Check the result first: it always belongs to an older byte.
      if (out_taken) begin
        seen.id          = out_ch.packet_id;
        seen.length      = out_ch.packet_length;
        seen.data        = out_ch.data_byte;
        seen.offset      = out_ch.payload_offset;
        seen.has_payload = out_ch.has_payload;
        seen.first       = out_ch.first_of_packet;
        seen.last        = out_ch.last_of_packet;
        seen.status      = out_ch.status;
        if (due_results.size() == 0) begin
          flag_error({"unexpected result ", fmt_result(seen)});
        end else begin
          want = due_results.pop_front();
          if (seen.id !== want.id || seen.length !== want.length ||
              seen.data !== want.data || seen.offset !== want.offset ||
              seen.has_payload !== want.has_payload || seen.first !== want.first ||
              seen.last !== want.last || seen.status !== want.status)
            flag_error({"result mismatch\n  expected ", fmt_result(want),
                        "\n  actual   ", fmt_result(seen)});
        end
      end

      // Unknown register indexes are dropped by the DUT; drop them here too.
      if (cfg_taken) begin
        if (cfg_ch.index == CFG_HEADER_LEN)
          m_hdr_len = cfg_ch.data[3:0];
        else if (cfg_ch.index == CFG_MAX_PACKET_LEN)
          m_max = cfg_ch.data;
      end

      if (in_taken)
        deframe_byte(in_ch.rx_byte, in_ch.flush);

      // Watchdog: end the run when nothing moves for too long.
      if (in_taken || out_taken || cfg_taken) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("length_prefixed_packet_deframer_tb failed");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stream driver: hold the byte until taken, then insert a gap or advance
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      drive_valid = 1'b0;
      if (in_gap_left != 0) begin
        in_gap_left--;
      end else if (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
        in_gap_left = $urandom_range(8, 1) - 1;
      end else if (rx_stream_q.size() != 0) begin
        drive_item = rx_stream_q.pop_front();
        in_ch.rx_byte <= drive_item.rx_byte;
        in_ch.flush   <= drive_item.flush;
        drive_valid = 1'b1;
      end
      in_ch.valid <= drive_valid;
    end
  end

  // Result receiver: stall in random bursts.
  always @(negedge clk) begin
    if (out_stall_left != 0) begin
      out_stall_left--;
      out_ch.ready <= 1'b0;
    end else if (out_stall_pct != 0 && $urandom_range(99) < out_stall_pct) begin
      out_stall_left = $urandom_range(8, 1) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void queue_item(logic [7:0] b, logic flush);
    stream_item_t it;
    it.rx_byte = b;
    it.flush   = flush;
    rx_stream_q.push_back(it);
    queued_items++;
  endfunction

  // Queue one packet under the current header length. A non-negative cut
  // smaller than the payload truncates it and closes with a flush.
  function automatic void queue_packet(logic [15:0] len, logic [15:0] id, int cut);
    int unsigned hl;
    int unsigned need;
    hl = eff_hdr_len();
    queue_item(len[7:0], 1'b0);
    queue_item(len[15:8], 1'b0);
    queue_item(id[7:0], 1'b0);
    queue_item(id[15:8], 1'b0);
    repeat (hl - 4) queue_item(8'($urandom), 1'b0);
    need = (len >= hl) ? len - hl : 0;
    if (cut < 0 || cut >= need) begin
      repeat (need) queue_item(8'($urandom), 1'b0);
    end else begin
      repeat (cut) queue_item(8'($urandom), 1'b0);
      queue_item(8'($urandom), 1'b1);
    end
  endfunction

  // Above the maximum (or all-ones at an all-ones maximum); long drops end in a flush.
  function automatic void queue_oversize();
    int unsigned hl;
    int unsigned extra;
    int unsigned len;
    hl = eff_hdr_len();
    if (m_max == 16'hFFFF) begin
      len = 16'hFFFF;
    end else begin
      extra = 16'hFFFF - m_max - 1;
      if (extra > 20) extra = 20;
      len = m_max + 1 + $urandom_range(extra);
    end
    if (len >= hl && len - hl > 64)
      queue_packet(16'(len), 16'($urandom), $urandom_range(16));
    else
      queue_packet(16'(len), 16'($urandom), -1);
  endfunction

  // Mostly well-formed packets with random content, the rest short, oversize,
  // truncated, noise or bare flushes.
  function automatic void queue_random_traffic(int unsigned n_items);
    int unsigned start, hl, span, top, len, need, pick;
    start = queued_items;
    hl    = eff_hdr_len();
    while (queued_items - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        if (m_max >= hl) begin
          top  = ($urandom_range(14) == 0) ? 300 : 24;
          span = m_max - hl;
          if (span < top) top = span;
          len  = hl + $urandom_range(top);
          need = len - hl;
          if (need > 0 && $urandom_range(9) == 0)
            queue_packet(16'(len), 16'($urandom), $urandom_range(need - 1));
          else
            queue_packet(16'(len), 16'($urandom), -1);
        end else begin
          queue_oversize();
        end
      end else if (pick < 75) begin
        queue_packet(16'($urandom_range(hl - 1)), 16'($urandom), -1);
      end else if (pick < 87) begin
        queue_oversize();
      end else if (pick < 95) begin
        repeat ($urandom_range(2 * hl, 1)) queue_item(8'($urandom), 1'b0);
        queue_item(8'($urandom), 1'b1);
      end else begin
        queue_item(8'($urandom), 1'b1);
      end
    end
  endfunction

  // Hold the sender until every queued byte is taken and every result is in,
  // then let the pipeline settle.
  task automatic wait_for_idle();
    do @(posedge clk);
    while (rx_stream_q.size() != 0 || in_ch.valid || due_results.size() != 0);
    repeat (PIPE_SETTLE) @(negedge clk);
  endtask

  // Called at a falling edge; returns at a falling edge after the transaction.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    cfg_ch.valid <= 1'b1;
    do @(negedge clk);
    while (!cfg_taken);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic reconfigure(input logic [3:0] hdr, input logic [15:0] max_len,
                             input int unsigned in_pct, input int unsigned out_pct);
    wait_for_idle();
    cfg_write(CFG_HEADER_LEN, {12'($urandom), hdr});
    cfg_write(CFG_MAX_PACKET_LEN, max_len);
    in_gap_pct    = in_pct;
    out_stall_pct = out_pct;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = 8'h00;
    in_ch.flush    = 1'b0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_HEADER_LEN;
    cfg_ch.data    = 16'h0000;
    in_gap_pct     = 20;
    out_stall_pct  = 20;
    in_gap_left    = 0;
    out_stall_left = 0;
    queued_items   = 0;
    mismatches     = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed, under reset configuration (header 5, max 4096):
    // header-only packet with all-ones id, short length zero, small payload,
    // oversize all-ones length cut by a flush.
    queue_packet(16'd5, 16'hFFFF, -1);
    queue_packet(16'd0, 16'h0000, -1);
    queue_packet(16'd7, 16'h1234, -1);
    queue_packet(16'hFFFF, 16'h8001, 2);
    // Start a header, then shrink header_len to 4 before it completes.
    queue_item(8'd9, 1'b0);
    queue_item(8'd0, 1'b0);

    reconfigure(4'd4, 16'hFFFF, 25, 25);
    queue_item(8'hA5, 1'b0);
    queue_item(8'h5A, 1'b0);
    queue_item(8'h00, 1'b0);
    queue_item(8'hFF, 1'b0);
    repeat (3) queue_item(8'($urandom), 1'b0);
    // Leave a 12-byte packet mid-payload across the next register change:
    // its payload size is already latched.
    queue_random_traffic(210);
    queue_packet(16'd12, 16'hC3C3, 3);
    rx_stream_q.pop_back();    // drop the closing flush, keep it in flight
    queued_items--;

    reconfigure(4'd8, 16'd40, 0, 0);
    repeat (5) queue_item(8'($urandom), 1'b0);
    queue_random_traffic(210);

    // Header_len below range acts as 4; max equal to the header size.
    reconfigure(4'd0, 16'd4, 10, 60);
    queue_random_traffic(200);

    // Header_len above range acts as 8; max zero makes every non-short packet oversize.
    reconfigure(4'd15, 16'd0, 50, 10);
    queue_random_traffic(200);

    // A write to an unused index must change nothing.
    reconfigure(4'd6, 16'd300, 30, 30);
    cfg_write(CFG_NO_REG, 16'($urandom));
    queue_random_traffic(220);

    // Closing stretch without any idling.
    reconfigure(4'd5, 16'd4096, 0, 0);
    queue_random_traffic(220);

    wait_for_idle();
    if (due_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", due_results.size()));
    if (mismatches == 0)
      $display("length_prefixed_packet_deframer_tb passed");
    else
      $display("length_prefixed_packet_deframer_tb failed");
    $finish;
  end

endmodule
